// ===== src/upd_pkg.sv =====
// Package: shared types, constants and hex helper for the URL percent decoder.
`timescale 1ns / 1ps
package upd_pkg;

  localparam logic [7:0] PctChar   = 8'h25;
  localparam int         FifoDepth = 4;

  typedef struct packed {
    logic [1:0]      cnt;
    logic [2:0][7:0] bytes;
    logic            last;
  } upd_grp_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } upd_hex_t;

  function automatic upd_hex_t hex_value(logic [7:0] c);
    upd_hex_t r;
    r.ok  = 1'b0;
    r.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.ok  = 1'b1;
      r.val = c[3:0];
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      r.ok  = 1'b1;
      r.val = c[3:0] + 4'd9;
    end
    return r;
  endfunction

endpackage

// ===== src/upd_if.sv =====
// Interfaces: input and output byte channels with valid/ready handshake.
`timescale 1ns / 1ps
interface upd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface upd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

// ===== src/upd_front.sv =====
// Front end: accepts input bytes, tracks escape state, builds result groups.
`timescale 1ns / 1ps
module upd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  upd_in_if.sink            in_i,
  input  logic              room_i,
  output logic              push_o,
  output upd_pkg::upd_grp_t grp_o
);
  import upd_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PCT,
    ST_PCT_DIG
  } state_e;

  state_e     state_q, state_d;
  logic [7:0] held_q, held_d;
  logic       take;
  upd_hex_t   h1, h2;
  logic [7:0] code;
  logic       code_ok;
  logic [7:0] b;
  logic       last;

  assign in_i.ready = room_i;
  assign take       = in_i.valid && room_i;
  assign b          = in_i.in_byte;
  assign last       = in_i.in_last;

  assign h1      = hex_value(held_q);
  assign h2      = hex_value(b);
  assign code    = {h1.val, h2.val};
  assign code_ok = h1.ok && h2.ok && !code[7] && (code[6:5] != 2'b00);

  always_comb begin
    state_d       = ST_IDLE;
    held_d        = held_q;
    grp_o.cnt     = 2'd0;
    grp_o.bytes   = {3{8'h00}};
    grp_o.last    = last;
    unique case (state_q)
      ST_PCT: begin
        if (last) begin
          grp_o.cnt      = 2'd2;
          grp_o.bytes[0] = PctChar;
          grp_o.bytes[1] = b;
        end else begin
          state_d = ST_PCT_DIG;
          held_d  = b;
        end
      end
      ST_PCT_DIG: begin
        grp_o.bytes[0] = PctChar;
        if (code_ok) begin
          grp_o.cnt      = 2'd1;
          grp_o.bytes[0] = code;
        end else if (held_q == PctChar) begin
          if (last) begin
            grp_o.cnt      = 2'd3;
            grp_o.bytes[1] = PctChar;
            grp_o.bytes[2] = b;
          end else begin
            grp_o.cnt = 2'd1;
            state_d   = ST_PCT_DIG;
            held_d    = b;
          end
        end else begin
          grp_o.bytes[1] = held_q;
          if (b == PctChar && !last) begin
            grp_o.cnt = 2'd2;
            state_d   = ST_PCT;
          end else begin
            grp_o.cnt      = 2'd3;
            grp_o.bytes[2] = b;
          end
        end
      end
      default: begin
        if (b == PctChar && !last) begin
          state_d = ST_PCT;
        end else begin
          grp_o.cnt      = 2'd1;
          grp_o.bytes[0] = b;
        end
      end
    endcase
  end

  assign push_o = take && (grp_o.cnt != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else if (take) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      held_q <= held_d;
    end
  end

endmodule

// ===== src/upd_fifo.sv =====
// Queue of result groups between front and back ends.
`timescale 1ns / 1ps
module upd_fifo #(
  parameter int Depth = upd_pkg::FifoDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  upd_pkg::upd_grp_t grp_i,
  output logic              room_o,
  input  logic              pop_i,
  output logic              avail_o,
  output upd_pkg::upd_grp_t grp_o
);
  import upd_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  upd_grp_t        mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_pop;

  assign room_o  = (cnt_q != CntW'(Depth));
  assign avail_o = (cnt_q != '0);
  assign grp_o   = mem_q[rd_q];
  assign do_pop  = pop_i && avail_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (push_i && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= grp_i;
    end
  end

endmodule

// ===== src/upd_back.sv =====
// Back end: serializes each result group onto the output channel.
`timescale 1ns / 1ps
module upd_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              avail_i,
  input  upd_pkg::upd_grp_t grp_i,
  output logic              pop_o,
  upd_out_if.source         out_o
);
  import upd_pkg::*;

  upd_grp_t   cur_q;
  logic [1:0] idx_q;
  logic       vld_q;
  logic       take;
  logic       at_end;
  logic       done;

  assign take   = vld_q && out_o.ready;
  assign at_end = (idx_q == cur_q.cnt - 2'd1);
  assign done   = !vld_q || (take && at_end);
  assign pop_o  = done && avail_i;

  assign out_o.valid    = vld_q;
  assign out_o.out_last = cur_q.last && at_end;

  always_comb begin
    unique case (idx_q)
      2'd1:    out_o.out_byte = cur_q.bytes[1];
      2'd2:    out_o.out_byte = cur_q.bytes[2];
      default: out_o.out_byte = cur_q.bytes[0];
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= 2'd0;
    end else if (done) begin
      vld_q <= avail_i;
      idx_q <= 2'd0;
    end else if (take) begin
      idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= grp_i;
    end
  end

endmodule

// ===== src/url_percent_decoder_unit.sv =====
// A result is held in the group queue and then in the back-end output register.
// Throughput: one request per cycle while the group queue has room; the back end emits
// one byte per cycle while the output is ready, so a request giving two or three
// bytes holds the output longer, and the group queue (FifoDepth entries) absorbs the difference.
// Reset: asynchronous active-low; clears escape state, queue and output valid.
`timescale 1ns / 1ps
module url_percent_decoder_unit #(
  parameter int FifoDepth = upd_pkg::FifoDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  upd_in_if.sink     in_i,
  upd_out_if.source  out_o
);
  import upd_pkg::*;

  logic     room, push, avail, pop;
  upd_grp_t grp_in, grp_out;

  upd_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .room_i (room),
    .push_o (push),
    .grp_o  (grp_in)
  );

  upd_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .grp_i   (grp_in),
    .room_o  (room),
    .pop_i   (pop),
    .avail_o (avail),
    .grp_o   (grp_out)
  );

  upd_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .avail_i (avail),
    .grp_i   (grp_out),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

// ===== src/upd_checker.sv =====
// Checker: port-level properties of the decoder, bound to the top level.
`timescale 1ns / 1ps
module upd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic       out_last_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_byte_i) && $stable(out_last_i))
    else $error("output payload changed while stalled");

  a_rise_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("output appeared without a request two cycles earlier");

  a_idle_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled while output is idle");

endmodule

bind url_percent_decoder_unit upd_checker u_upd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_byte_i  (out_o.out_byte),
  .out_last_i  (out_o.out_last)
);
